/* rtl/core/lift_dump_sequencer_unit_assert.svh */
// Assertion macros shared by the lift dump sequencer RTL.
// Each use names the check, the trigger and the condition that must hold.
`ifndef LIFT_DUMP_SEQUENCER_UNIT_ASSERT_SVH
`define LIFT_DUMP_SEQUENCER_UNIT_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define LDS_ASSERT_NOW(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) \
    else $error("lds check failed");

// condition must hold in the cycle after the trigger
`define LDS_ASSERT_NEXT(label, trig, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) \
    else $error("lds check failed");

`endif

/* rtl/core/lds_pkg.sv */
// ----------------------------------------------------------------------------
// lds_pkg
// Types and codes for the lift dump sequencer: payload structs, opcodes,
// phase and mode encodings, register map.
// ----------------------------------------------------------------------------
`default_nettype none

package lds_pkg;

  // request opcodes
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_DUMP   = 3'd1;
  localparam logic [2:0] OP_RESET  = 3'd2;
  localparam logic [2:0] OP_EXTEND = 3'd3;
  localparam logic [2:0] OP_RAISE  = 3'd4;
  localparam logic [2:0] OP_STOP   = 3'd5;

  // reported phase codes
  localparam logic [1:0] PHC_IDLE  = 2'd0;
  localparam logic [1:0] PHC_BEGIN = 2'd1;
  localparam logic [1:0] PHC_RAISE = 2'd2;
  localparam logic [1:0] PHC_LOWER = 2'd3;

  // reported manual mode codes
  localparam logic [1:0] MDC_NONE   = 2'd0;
  localparam logic [1:0] MDC_RESET  = 2'd1;
  localparam logic [1:0] MDC_EXTEND = 2'd2;
  localparam logic [1:0] MDC_RAISE  = 2'd3;

  // motor drive codes
  localparam logic signed [1:0] DRV_OFF  = 2'sb00;
  localparam logic signed [1:0] DRV_UP   = 2'sb01;
  localparam logic signed [1:0] DRV_DOWN = 2'sb11;

  // register map
  localparam int unsigned AddrWidth = 4;
  localparam logic [AddrWidth-1:0] REG_TURNS_TO_LIMIT  = 4'h0;
  localparam logic [AddrWidth-1:0] REG_GATE_OPEN_TICKS = 4'h4;
  localparam logic [AddrWidth-1:0] REG_DEBOUNCE_TICKS  = 4'h8;

  localparam logic [7:0]  TURNS_TO_LIMIT_RST  = 8'd6;
  localparam logic [15:0] GATE_OPEN_TICKS_RST = 16'd150;
  localparam logic [7:0]  DEBOUNCE_TICKS_RST  = 8'd2;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'b0001,
    PH_BEGIN = 4'b0010,
    PH_RAISE = 4'b0100,
    PH_LOWER = 4'b1000
  } phase_t;

  typedef enum logic [3:0] {
    MD_NONE   = 4'b0001,
    MD_RESET  = 4'b0010,
    MD_EXTEND = 4'b0100,
    MD_RAISE  = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic       count_switch;
    logic       top_limit;
    logic       bottom_limit;
  } req_t;

  typedef struct packed {
    logic signed [1:0] motor_drive;
    logic              gate_tilted;
    logic [1:0]        dump_phase;
    logic [7:0]        turn_count_out;
    logic [1:0]        manual_mode;
  } rsp_t;

endpackage

`default_nettype wire

/* rtl/core/lift_dump_sequencer_unit.sv */
// ----------------------------------------------------------------------------
// lift_dump_sequencer_unit
// Tick-driven controller for a lifting dump bucket: dump sequence, manual
// reset/extend/raise-to-height modes, debounced turn counting, gate timer.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  req       in   req_valid/req_stall  lds_pkg::req_t (one control tick)
//  rsp       out  rsp_valid/rsp_stall  lds_pkg::rsp_t (drive, gate, phase...)
//  apb       in   psel/penable/pready  three config registers at 0x0/0x4/0x8
//
//  Each request passes through the input register, then through the tick logic
//  into the response register; one request per cycle while rsp is not stalled.
//  The sequencer state updates as the input register hands its tick on.
//  rst is synchronous, active high; it clears state and loads register defaults.
//  A stalled response holds the input register, which then stalls req.
`default_nettype none

module lift_dump_sequencer_unit (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           req_valid,
  output logic                                req_stall,
  input  wire lds_pkg::req_t                  req,
  output logic                                rsp_valid,
  input  wire logic                           rsp_stall,
  output lds_pkg::rsp_t                       rsp,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [lds_pkg::AddrWidth-1:0]  paddr,
  input  wire logic [31:0]                    pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  // configuration
  logic [7:0]  turns_to_limit;
  logic [15:0] gate_open_ticks;
  logic [7:0]  debounce_ticks;

  // sequencer state
  lds_pkg::phase_t   phase, phase_next;
  lds_pkg::mode_t    mode, mode_next;
  logic [7:0]        turn_count, turn_count_next;
  logic              pulse_latched, pulse_latched_next;
  logic [15:0]       gate_timer, gate_timer_next;
  logic              gate_timer_running, gate_timer_running_next;
  logic [7:0]        pulse_timer, pulse_timer_next;
  logic              pulse_timer_running, pulse_timer_running_next;
  logic signed [1:0] drive_held, drive_held_next;
  logic              gate_held, gate_held_next;

  // pipeline
  logic          s1_valid;
  lds_pkg::req_t s1_req;
  logic          rsp_free;
  logic          s1_adv;
  logic          req_take;
  lds_pkg::rsp_t rsp_next;

  assign pready   = 1'b1;
  assign rsp_free = !rsp_valid || !rsp_stall;
  assign s1_adv   = s1_valid && rsp_free;
  assign req_stall = s1_valid && !rsp_free;
  assign req_take = req_valid && !req_stall;

  // --------------------------------------------------------------------------
  // register port
  always_ff @(posedge clk) begin
    if (rst) begin
      turns_to_limit  <= lds_pkg::TURNS_TO_LIMIT_RST;
      gate_open_ticks <= lds_pkg::GATE_OPEN_TICKS_RST;
      debounce_ticks  <= lds_pkg::DEBOUNCE_TICKS_RST;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr)
        lds_pkg::REG_TURNS_TO_LIMIT:  turns_to_limit  <= pwdata[7:0];
        lds_pkg::REG_GATE_OPEN_TICKS: gate_open_ticks <= pwdata[15:0];
        lds_pkg::REG_DEBOUNCE_TICKS:  debounce_ticks  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      lds_pkg::REG_TURNS_TO_LIMIT:  prdata = {24'd0, turns_to_limit};
      lds_pkg::REG_GATE_OPEN_TICKS: prdata = {16'd0, gate_open_ticks};
      lds_pkg::REG_DEBOUNCE_TICKS:  prdata = {24'd0, debounce_ticks};
      default:                      prdata = 32'd0;
    endcase
  end

  // --------------------------------------------------------------------------
  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      s1_req <= req;
    end
  end

  // --------------------------------------------------------------------------
  // one control tick: command, dump sequence, manual modes, re-arm, timers
  always_comb begin
    logic sw;
    logic top;
    logic bottom;
    sw     = s1_req.count_switch;
    top    = s1_req.top_limit;
    bottom = s1_req.bottom_limit;

    phase_next               = phase;
    mode_next                = mode;
    turn_count_next          = turn_count;
    pulse_latched_next       = pulse_latched;
    gate_timer_next          = gate_timer;
    gate_timer_running_next  = gate_timer_running;
    pulse_timer_next         = pulse_timer;
    pulse_timer_running_next = pulse_timer_running;
    drive_held_next          = drive_held;
    gate_held_next           = gate_held;

    case (s1_req.opcode)
      lds_pkg::OP_DUMP: begin
        if (phase == lds_pkg::PH_IDLE) begin
          phase_next = lds_pkg::PH_BEGIN;
        end
      end
      lds_pkg::OP_RESET:  mode_next = lds_pkg::MD_RESET;
      lds_pkg::OP_EXTEND: mode_next = lds_pkg::MD_EXTEND;
      lds_pkg::OP_RAISE: begin
        mode_next       = lds_pkg::MD_RAISE;
        turn_count_next = 8'd0;
      end
      lds_pkg::OP_STOP: begin
        drive_held_next = lds_pkg::DRV_OFF;
        phase_next      = lds_pkg::PH_IDLE;
        mode_next       = lds_pkg::MD_NONE;
      end
      default: ;
    endcase

    unique case (phase_next)
      lds_pkg::PH_BEGIN: begin
        turn_count_next = 8'd0;
        drive_held_next = lds_pkg::DRV_UP;
        phase_next      = lds_pkg::PH_RAISE;
      end
      lds_pkg::PH_RAISE: begin
        if ((sw && !pulse_latched_next) || (gate_timer_next >= gate_open_ticks) || top) begin
          if (turn_count_next != 8'hFF) begin
            turn_count_next = turn_count_next + 8'd1;
          end
          pulse_latched_next       = 1'b1;
          pulse_timer_running_next = 1'b1;
          if ((turn_count_next >= turns_to_limit) || top) begin
            drive_held_next         = lds_pkg::DRV_OFF;
            gate_held_next          = 1'b1;
            gate_timer_running_next = 1'b1;
            // gate time already spent: drop the gate and start lowering
            if (gate_timer_next >= gate_open_ticks) begin
              gate_timer_running_next = 1'b0;
              gate_timer_next         = 16'd0;
              gate_held_next          = 1'b0;
              drive_held_next         = lds_pkg::DRV_DOWN;
              phase_next              = lds_pkg::PH_LOWER;
              turn_count_next         = 8'd0;
            end
          end
        end
      end
      lds_pkg::PH_LOWER: begin
        if (bottom) begin
          drive_held_next = lds_pkg::DRV_OFF;
          phase_next      = lds_pkg::PH_IDLE;
          turn_count_next = 8'd0;
        end
      end
      default: ;
    endcase

    // manual modes in order; the last drive written wins
    if (mode_next == lds_pkg::MD_RESET) begin
      if (!bottom) begin
        drive_held_next = lds_pkg::DRV_DOWN;
        gate_held_next  = 1'b0;
        phase_next      = lds_pkg::PH_IDLE;
      end else begin
        drive_held_next = lds_pkg::DRV_OFF;
        mode_next       = lds_pkg::MD_NONE;
      end
    end
    if (mode_next == lds_pkg::MD_EXTEND) begin
      if (!top) begin
        drive_held_next = lds_pkg::DRV_UP;
        phase_next      = lds_pkg::PH_IDLE;
      end else begin
        drive_held_next = lds_pkg::DRV_OFF;
        mode_next       = lds_pkg::MD_NONE;
      end
    end
    if (mode_next == lds_pkg::MD_RAISE) begin
      drive_held_next = lds_pkg::DRV_UP;
      if ((sw && !pulse_latched_next) || top) begin
        pulse_latched_next       = 1'b1;
        pulse_timer_running_next = 1'b1;
        if (turn_count_next != 8'hFF) begin
          turn_count_next = turn_count_next + 8'd1;
        end
        if ((turn_count_next >= turns_to_limit) || top) begin
          drive_held_next = lds_pkg::DRV_OFF;
          mode_next       = lds_pkg::MD_NONE;
          turn_count_next = 8'd0;
        end
      end
    end

    // re-arm the pulse latch once the switch is released and debounce is over
    if (!sw && (pulse_timer_next >= debounce_ticks)) begin
      pulse_latched_next       = 1'b0;
      pulse_timer_running_next = 1'b0;
      pulse_timer_next         = 8'd0;
    end

    if (gate_timer_running_next && (gate_timer_next != 16'hFFFF)) begin
      gate_timer_next = gate_timer_next + 16'd1;
    end
    if (pulse_timer_running_next && (pulse_timer_next != 8'hFF)) begin
      pulse_timer_next = pulse_timer_next + 8'd1;
    end
  end

  // response fields from the next state
  always_comb begin
    rsp_next.motor_drive    = drive_held_next;
    rsp_next.gate_tilted    = gate_held_next;
    rsp_next.turn_count_out = turn_count_next;
    unique case (phase_next)
      lds_pkg::PH_BEGIN: rsp_next.dump_phase = lds_pkg::PHC_BEGIN;
      lds_pkg::PH_RAISE: rsp_next.dump_phase = lds_pkg::PHC_RAISE;
      lds_pkg::PH_LOWER: rsp_next.dump_phase = lds_pkg::PHC_LOWER;
      default:           rsp_next.dump_phase = lds_pkg::PHC_IDLE;
    endcase
    unique case (mode_next)
      lds_pkg::MD_RESET:  rsp_next.manual_mode = lds_pkg::MDC_RESET;
      lds_pkg::MD_EXTEND: rsp_next.manual_mode = lds_pkg::MDC_EXTEND;
      lds_pkg::MD_RAISE:  rsp_next.manual_mode = lds_pkg::MDC_RAISE;
      default:            rsp_next.manual_mode = lds_pkg::MDC_NONE;
    endcase
  end

  // --------------------------------------------------------------------------
  // state and response registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase               <= lds_pkg::PH_IDLE;
      mode                <= lds_pkg::MD_NONE;
      turn_count          <= 8'd0;
      pulse_latched       <= 1'b0;
      gate_timer          <= 16'd0;
      gate_timer_running  <= 1'b0;
      pulse_timer         <= 8'd0;
      pulse_timer_running <= 1'b0;
      drive_held          <= lds_pkg::DRV_OFF;
      gate_held           <= 1'b0;
    end else if (s1_adv) begin
      phase               <= phase_next;
      mode                <= mode_next;
      turn_count          <= turn_count_next;
      pulse_latched       <= pulse_latched_next;
      gate_timer          <= gate_timer_next;
      gate_timer_running  <= gate_timer_running_next;
      pulse_timer         <= pulse_timer_next;
      pulse_timer_running <= pulse_timer_running_next;
      drive_held          <= drive_held_next;
      gate_held           <= gate_held_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s1_adv) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      rsp <= rsp_next;
    end
  end

  // --------------------------------------------------------------------------
  // checks
`include "lift_dump_sequencer_unit_assert.svh"

  // latch and debounce timer are set and cleared together
  `LDS_ASSERT_NOW(a_latch_timer_pair, 1'b1, pulse_latched == pulse_timer_running)
  // a request is never taken over a held input register
  `LDS_ASSERT_NOW(a_no_overwrite, req_valid && !req_stall, !s1_valid || s1_adv)
  // sequencer state moves only with a tick
  `LDS_ASSERT_NEXT(a_state_hold, !s1_adv, $stable(phase) && $stable(turn_count))

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: lift dump sequencer unit testbench
// Sends control ticks through the request channel under random sender gaps
// and receiver stalls, predicts each tick's drive/gate/phase/count/mode from
// a cycle-free model of the sequencer, and checks every response in order.
// Configuration goes through the APB port between phases, with read-back.
// ----------------------------------------------------------------------------
module tb_top;

  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;
  localparam int unsigned StallLimit = 2000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  lds_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  lds_pkg::rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [lds_pkg::AddrWidth-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  lift_dump_sequencer_unit u_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // sequencer model state and its copy of the registers
  logic [1:0]        seq_phase = lds_pkg::PHC_IDLE;
  logic [7:0]        turns = '0;
  bit                pulse_seen = 1'b0;
  logic [15:0]       gate_tmr = '0;
  bit                gate_tmr_on = 1'b0;
  logic [7:0]        pulse_tmr = '0;
  bit                pulse_tmr_on = 1'b0;
  logic [1:0]        manual = lds_pkg::MDC_NONE;
  logic signed [1:0] drive = lds_pkg::DRV_OFF;
  bit                gate_open = 1'b0;
  logic [7:0]        turn_limit = lds_pkg::TURNS_TO_LIMIT_RST;
  logic [15:0]       gate_limit = lds_pkg::GATE_OPEN_TICKS_RST;
  logic [7:0]        debounce_limit = lds_pkg::DEBOUNCE_TICKS_RST;

  lds_pkg::rsp_t expected_status[$];
  lds_pkg::rsp_t want;
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int burst_left = 0;
  bit quiet = 1'b0;
  bit sw_level = 1'b0;
  int unsigned stall_clock = 0;
  int stall_style = 0;

  function automatic void count_turn();
    if (turns != 8'hFF) turns = turns + 8'd1;
  endfunction

  function automatic lds_pkg::rsp_t advance_tick(lds_pkg::req_t t);
    lds_pkg::rsp_t r;
    bit sw;
    bit top;
    bit bot;
    sw = t.count_switch;
    top = t.top_limit;
    bot = t.bottom_limit;
    case (t.opcode)
      lds_pkg::OP_DUMP:   if (seq_phase == lds_pkg::PHC_IDLE) seq_phase = lds_pkg::PHC_BEGIN;
      lds_pkg::OP_RESET:  manual = lds_pkg::MDC_RESET;
      lds_pkg::OP_EXTEND: manual = lds_pkg::MDC_EXTEND;
      lds_pkg::OP_RAISE: begin
        manual = lds_pkg::MDC_RAISE;
        turns = '0;
      end
      lds_pkg::OP_STOP: begin
        drive = lds_pkg::DRV_OFF;
        seq_phase = lds_pkg::PHC_IDLE;
        manual = lds_pkg::MDC_NONE;
      end
      default: ;
    endcase
    case (seq_phase)
      lds_pkg::PHC_BEGIN: begin
        turns = '0;
        drive = lds_pkg::DRV_UP;
        seq_phase = lds_pkg::PHC_RAISE;
      end
      lds_pkg::PHC_RAISE: begin
        if ((sw && !pulse_seen) || gate_tmr >= gate_limit || top) begin
          count_turn();
          pulse_seen = 1'b1;
          pulse_tmr_on = 1'b1;
          if (turns >= turn_limit || top) begin
            drive = lds_pkg::DRV_OFF;
            gate_open = 1'b1;
            gate_tmr_on = 1'b1;
            if (gate_tmr >= gate_limit) begin
              gate_tmr_on = 1'b0;
              gate_tmr = '0;
              gate_open = 1'b0;
              drive = lds_pkg::DRV_DOWN;
              seq_phase = lds_pkg::PHC_LOWER;
              turns = '0;
            end
          end
        end
      end
      lds_pkg::PHC_LOWER: begin
        if (bot) begin
          drive = lds_pkg::DRV_OFF;
          seq_phase = lds_pkg::PHC_IDLE;
          turns = '0;
        end
      end
      default: ;
    endcase
    // manual modes run in order; the last drive written wins
    if (manual == lds_pkg::MDC_RESET) begin
      if (!bot) begin
        drive = lds_pkg::DRV_DOWN;
        gate_open = 1'b0;
        seq_phase = lds_pkg::PHC_IDLE;
      end else begin
        drive = lds_pkg::DRV_OFF;
        manual = lds_pkg::MDC_NONE;
      end
    end
    if (manual == lds_pkg::MDC_EXTEND) begin
      if (!top) begin
        drive = lds_pkg::DRV_UP;
        seq_phase = lds_pkg::PHC_IDLE;
      end else begin
        drive = lds_pkg::DRV_OFF;
        manual = lds_pkg::MDC_NONE;
      end
    end
    if (manual == lds_pkg::MDC_RAISE) begin
      drive = lds_pkg::DRV_UP;
      if ((sw && !pulse_seen) || top) begin
        pulse_seen = 1'b1;
        pulse_tmr_on = 1'b1;
        count_turn();
        if (turns >= turn_limit || top) begin
          drive = lds_pkg::DRV_OFF;
          manual = lds_pkg::MDC_NONE;
          turns = '0;
        end
      end
    end
    if (!sw && pulse_tmr >= debounce_limit) begin
      pulse_seen = 1'b0;
      pulse_tmr_on = 1'b0;
      pulse_tmr = '0;
    end
    if (gate_tmr_on && gate_tmr != 16'hFFFF) gate_tmr = gate_tmr + 16'd1;
    if (pulse_tmr_on && pulse_tmr != 8'hFF) pulse_tmr = pulse_tmr + 8'd1;
    r.motor_drive = drive;
    r.gate_tilted = gate_open;
    r.dump_phase = seq_phase;
    r.turn_count_out = turns;
    r.manual_mode = manual;
    return r;
  endfunction

  function automatic lds_pkg::req_t tick(logic [2:0] op, bit sw, bit top, bit bot);
    lds_pkg::req_t t;
    t.opcode = op;
    t.count_switch = sw;
    t.top_limit = top;
    t.bottom_limit = bot;
    return t;
  endfunction

  // mostly plain ticks with a bouncing count switch; commands now and then
  function automatic lds_pkg::req_t random_tick();
    int unsigned pick;
    logic [2:0] op;
    pick = $urandom_range(0, 99);
    if ($urandom_range(0, 2) == 0) sw_level = ~sw_level;
    if (pick < 6) op = lds_pkg::OP_DUMP;
    else if (pick < 9) op = lds_pkg::OP_RESET;
    else if (pick < 12) op = lds_pkg::OP_EXTEND;
    else if (pick < 15) op = lds_pkg::OP_RAISE;
    else if (pick < 17) op = lds_pkg::OP_STOP;
    else if (pick < 18) op = OP_SPARE_6;
    else if (pick < 19) op = OP_SPARE_7;
    else op = lds_pkg::OP_NONE;
    return tick(op, sw_level, $urandom_range(0, 9) == 0, $urandom_range(0, 4) == 0);
  endfunction

  task automatic apply_tick(input lds_pkg::req_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = quiet ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        @(negedge clk);
        req_valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    req_valid <= 1'b1;
    req <= t;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_status.push_back(advance_tick(t));
    burst_left--;
  endtask

  task automatic apply_random(input int n);
    repeat (n) apply_tick(random_tick());
  endtask

  // hold requests off until every response is back
  task automatic drain();
    @(negedge clk);
    req_valid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(input logic [lds_pkg::AddrWidth-1:0] addr,
                           input logic [31:0] value);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== value) begin
      $display("%0t: register 0x%h expected %0d got %0d", $time, addr, value, prdata);
      mismatch_count++;
    end
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (addr)
      lds_pkg::REG_TURNS_TO_LIMIT:  turn_limit = value[7:0];
      lds_pkg::REG_GATE_OPEN_TICKS: gate_limit = value[15:0];
      lds_pkg::REG_DEBOUNCE_TICKS:  debounce_limit = value[7:0];
      default: ;
    endcase
  endtask

  task automatic set_limits(input logic [7:0] t, input logic [15:0] g, input logic [7:0] d);
    drain();
    write_reg(lds_pkg::REG_TURNS_TO_LIMIT, {24'd0, t});
    write_reg(lds_pkg::REG_GATE_OPEN_TICKS, {16'd0, g});
    write_reg(lds_pkg::REG_DEBOUNCE_TICKS, {24'd0, d});
  endtask

  // every opcode and mode at reset defaults
  task automatic test_commands();
    apply_tick(tick(OP_SPARE_6, 1'b1, 1'b1, 1'b1));
    apply_tick(tick(OP_SPARE_7, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_EXTEND, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b1, 1'b0));
    apply_tick(tick(lds_pkg::OP_RESET, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_DUMP, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b1));
    apply_tick(tick(lds_pkg::OP_RAISE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b1, 1'b0));
    apply_tick(tick(lds_pkg::OP_DUMP, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_DUMP, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b1, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_STOP, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b1));
  endtask

  // zero turn limit and debounce, gate open ticks set to one
  task automatic test_zero_limits();
    set_limits(8'd0, 16'd1, 8'd0);
    apply_tick(tick(lds_pkg::OP_DUMP, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b1));
    apply_tick(tick(lds_pkg::OP_RAISE, 1'b1, 1'b0, 1'b0));
    apply_random(40);
  endtask

  // largest limits: pulse timer and turn count saturate
  task automatic test_saturation();
    set_limits(8'hFF, 16'hFFFF, 8'hFF);
    apply_tick(tick(lds_pkg::OP_DUMP, 1'b0, 1'b0, 1'b0));
    // hold switch and top limit back to back so every tick counts a turn
    quiet = 1'b1;
    repeat (262) apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b1, 1'b0));
    quiet = 1'b0;
    apply_tick(tick(lds_pkg::OP_NONE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_STOP, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_RAISE, 1'b0, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_NONE, 1'b1, 1'b0, 1'b0));
    apply_tick(tick(lds_pkg::OP_STOP, 1'b0, 1'b0, 1'b0));
  endtask

  task automatic test_random_traffic();
    set_limits(8'd3, 16'd10, 8'd1);
    apply_random(40);
    set_limits(8'd0, 16'd1, 8'd0);
    apply_random(40);
    set_limits(8'($urandom_range(1, 8)), 16'($urandom_range(1, 30)),
               8'($urandom_range(0, 4)));
    apply_random(40);
    set_limits(8'hFF, 16'hFFFF, 8'hFF);
    apply_random(40);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_commands();
    test_zero_limits();
    test_saturation();
    test_random_traffic();
    drain();
    repeat (6) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // receiver stalls in styles that change whenever the low seven bits of stall_clock are zero
  always @(negedge clk) begin
    stall_clock <= stall_clock + 1;
    if (stall_clock[6:0] == 7'd0) stall_style <= $urandom_range(0, 3);
    case (stall_style)
      0: rsp_stall <= 1'b0;
      1: rsp_stall <= ($urandom_range(0, 3) == 0);
      2: rsp_stall <= (stall_clock % 5 < 2);
      default: rsp_stall <= ($urandom_range(0, 1) == 1);
    endcase
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (expected_status.size() == 0) begin
        $display("%0t: response with none expected: %h", $time, rsp);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        if (rsp.motor_drive !== want.motor_drive) begin
          $display("%0t: motor_drive expected %0d got %0d", $time,
                   want.motor_drive, rsp.motor_drive);
          mismatch_count++;
        end
        if (rsp.gate_tilted !== want.gate_tilted) begin
          $display("%0t: gate_tilted expected %0d got %0d", $time,
                   want.gate_tilted, rsp.gate_tilted);
          mismatch_count++;
        end
        if (rsp.dump_phase !== want.dump_phase) begin
          $display("%0t: dump_phase expected %0d got %0d", $time,
                   want.dump_phase, rsp.dump_phase);
          mismatch_count++;
        end
        if (rsp.turn_count_out !== want.turn_count_out) begin
          $display("%0t: turn_count_out expected %0d got %0d", $time,
                   want.turn_count_out, rsp.turn_count_out);
          mismatch_count++;
        end
        if (rsp.manual_mode !== want.manual_mode) begin
          $display("%0t: manual_mode expected %0d got %0d", $time,
                   want.manual_mode, rsp.manual_mode);
          mismatch_count++;
        end
      end
    end
  end

  // drop the run if neither channel moves for too long
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("%0t: no request or response accepted for %0d cycles", $time, idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
